@@ rtl/core/pclbc_pkg.sv @@
// -----------------------------------------------------------------------------
// Pixel color to LED bit codes: shared package
// Field types, configuration register indexes and sizes used across the block.
// -----------------------------------------------------------------------------
package pclbc_pkg;

   localparam int HUE_W          = 9;
   localparam int BYTE_W         = 8;
   localparam int CODE_W         = 16;
   localparam int CHANNEL_W      = 2;
   localparam int BIT_INDEX_W    = 3;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int BITS_PER_PIXEL = 24;
   localparam int POS_W          = 5;

   typedef logic [HUE_W-1:0]       hue_type;
   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [CODE_W-1:0]      code_type;
   typedef logic [CHANNEL_W-1:0]   channel_type;
   typedef logic [BIT_INDEX_W-1:0] bit_index_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   typedef struct packed {
      byte_type red;
      byte_type green;
      byte_type blue;
   } color_type;

   typedef struct packed {
      code_type one_code;
      code_type zero_code;
   } code_cfg_type;

   // Configuration register indexes.
   localparam csr_index_type CSR_COLOR_MODE = 2'd0;
   localparam csr_index_type CSR_ONE_CODE   = 2'd1;
   localparam csr_index_type CSR_ZERO_CODE  = 2'd2;

   // Color mode codes.
   localparam logic MODE_RGB = 1'b0;
   localparam logic MODE_HSV = 1'b1;

endpackage

@@ rtl/core/pclbc_if.sv @@
// -----------------------------------------------------------------------------
// Pixel color to LED bit codes: channel interfaces
// Valid/ready channels for pixel requests and for code word results.
// -----------------------------------------------------------------------------
interface pclbc_req_if ();
   import pclbc_pkg::*;

   logic     valid;
   logic     ready;
   hue_type  hue_or_red;
   byte_type sat_or_green;
   byte_type val_or_blue;

   modport source (output valid, output hue_or_red, output sat_or_green,
                   output val_or_blue, input ready);
   modport sink   (input valid, input hue_or_red, input sat_or_green,
                   input val_or_blue, output ready);
endinterface

interface pclbc_rsp_if ();
   import pclbc_pkg::*;

   logic          valid;
   logic          ready;
   code_type      code_word;
   channel_type   channel;
   bit_index_type bit_index;
   logic          last;

   modport source (output valid, output code_word, output channel,
                   output bit_index, output last, input ready);
   modport sink   (input valid, input code_word, input channel,
                   input bit_index, input last, output ready);
endinterface

@@ rtl/core/pclbc_color_pipe.sv @@
// -----------------------------------------------------------------------------
// Pixel color to LED bit codes: color conversion pipeline
// Six-stage pipeline that turns clamped HSV or raw RGB input into RGB bytes.
// -----------------------------------------------------------------------------
module pclbc_color_pipe (
   input  logic                  clock,
   input  logic                  reset,
   pclbc_req_if.sink             req_chan,
   input  logic                  color_mode,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pclbc_pkg::color_type  out_color
);
   import pclbc_pkg::*;

   localparam int STAGES = 6;

   localparam hue_type    HUE_MAX  = 9'd360;
   localparam logic [6:0] PCT_MAX  = 7'd100;
   localparam byte_type   PCT_CLIP = 8'd100;

   // Hue sectors of sixty degrees each.
   localparam logic [2:0] SECT_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECT_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECT_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECT_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECT_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SECT_MAGENTA_RED   = 3'd5;

   // c+m = 51*v/20, x+m = 17*n/40000, m = 51*w/2000, all truncated.
   localparam int SCALE_CM = 51;
   localparam int SCALE_MM = 51;
   localparam int SCALE_XM = 17;
   localparam int CM_DIV   = 20;
   localparam int MM_DIV   = 2000;
   localparam int XM_DIV   = 40000;
   localparam int CM_SHIFT = 13;
   localparam int MM_SHIFT = 19;
   localparam int XM_SHIFT = 24;
   localparam int CM_RECIP = (1 << CM_SHIFT) / CM_DIV;
   localparam int MM_RECIP = (1 << MM_SHIFT) / MM_DIV;
   localparam int XM_RECIP = (1 << XM_SHIFT) / XM_DIV;
   localparam int RECIP_W  = 9;

   localparam int T_W  = 13;
   localparam int W_W  = 14;
   localparam int X1_W = 13;
   localparam int N_W  = 20;
   localparam int X2_W = 19;
   localparam int X3_W = 24;
   localparam int P1_W = X1_W + RECIP_W;
   localparam int P2_W = X2_W + RECIP_W;
   localparam int P3_W = X3_W + RECIP_W;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;

   // Stage 1: clamp, sector and distance to the nearest hue of 60, 180 or 300.
   hue_type    hue_clamp;
   logic [6:0] hue_mod;
   logic       st1_mode_ff,   st1_mode_in;
   color_type  st1_raw_ff,    st1_raw_in;
   logic [2:0] st1_sector_ff, st1_sector_in;
   logic [5:0] st1_dist_ff,   st1_dist_in;
   logic [6:0] st1_sat_ff,    st1_sat_in;
   logic [6:0] st1_val_ff,    st1_val_in;

   // Stage 2: first products.
   logic [6:0]      sat_inv;
   logic            st2_mode_ff,   st2_mode_in;
   color_type       st2_raw_ff,    st2_raw_in;
   logic [2:0]      st2_sector_ff, st2_sector_in;
   logic [6:0]      st2_val_ff,    st2_val_in;
   logic [T_W-1:0]  st2_t_ff,      st2_t_in;
   logic [W_W-1:0]  st2_w_ff,      st2_w_in;
   logic [X1_W-1:0] st2_x1_ff,     st2_x1_in;

   // Stage 3: dividends.
   logic            st3_mode_ff,   st3_mode_in;
   color_type       st3_raw_ff,    st3_raw_in;
   logic [2:0]      st3_sector_ff, st3_sector_in;
   logic [N_W-1:0]  st3_n_ff,      st3_n_in;
   logic [X2_W-1:0] st3_x2_ff,     st3_x2_in;
   logic [X1_W-1:0] st3_x1_ff,     st3_x1_in;

   // Stage 4: reciprocal estimates for c+m and m.
   logic [P1_W-1:0] prod_cm;
   logic [P2_W-1:0] prod_mm;
   logic            st4_mode_ff,   st4_mode_in;
   color_type       st4_raw_ff,    st4_raw_in;
   logic [2:0]      st4_sector_ff, st4_sector_in;
   logic [X3_W-1:0] st4_x3_ff,     st4_x3_in;
   logic [X1_W-1:0] st4_x1_ff,     st4_x1_in;
   logic [X2_W-1:0] st4_x2_ff,     st4_x2_in;
   byte_type        st4_qcm_ff,    st4_qcm_in;
   byte_type        st4_qmm_ff,    st4_qmm_in;

   // Stage 5: corrections for c+m and m, estimate for x+m.
   logic [P3_W-1:0] prod_xm;
   logic [X1_W-1:0] rem_cm;
   logic [X2_W-1:0] rem_mm;
   logic            st5_mode_ff,   st5_mode_in;
   color_type       st5_raw_ff,    st5_raw_in;
   logic [2:0]      st5_sector_ff, st5_sector_in;
   logic [X3_W-1:0] st5_x3_ff,     st5_x3_in;
   byte_type        st5_qxm_ff,    st5_qxm_in;
   byte_type        st5_cm_ff,     st5_cm_in;
   byte_type        st5_mm_ff,     st5_mm_in;

   // Stage 6: correction for x+m and sector select.
   logic [X3_W-1:0] rem_xm;
   byte_type        xm;
   color_type       hsv_color;
   color_type       st6_color_ff,  st6_color_in;

   // Handshake: a stage takes new data when it is empty or moving on.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in = {valid_ff[STAGES-2:0], req_chan.valid};
   end

   assign req_chan.ready = adv[0];
   assign out_valid      = valid_ff[STAGES-1];
   assign out_color      = st6_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Stage 1 logic.
   always_comb begin
      hue_clamp = (req_chan.hue_or_red > HUE_MAX) ? HUE_MAX : req_chan.hue_or_red;
      st1_sat_in = (req_chan.sat_or_green > PCT_CLIP) ? PCT_MAX
                                                      : req_chan.sat_or_green[6:0];
      st1_val_in = (req_chan.val_or_blue > PCT_CLIP) ? PCT_MAX
                                                     : req_chan.val_or_blue[6:0];
      priority if (hue_clamp >= 9'd240) begin
         hue_mod = 7'(hue_clamp - 9'd240);
      end else if (hue_clamp >= 9'd120) begin
         hue_mod = 7'(hue_clamp - 9'd120);
      end else begin
         hue_mod = hue_clamp[6:0];
      end
      st1_dist_in = (hue_mod >= 7'd60) ? 6'(hue_mod - 7'd60) : 6'(7'd60 - hue_mod);
      priority if (hue_clamp >= 9'd300) begin
         st1_sector_in = SECT_MAGENTA_RED;
      end else if (hue_clamp >= 9'd240) begin
         st1_sector_in = SECT_BLUE_MAGENTA;
      end else if (hue_clamp >= 9'd180) begin
         st1_sector_in = SECT_CYAN_BLUE;
      end else if (hue_clamp >= 9'd120) begin
         st1_sector_in = SECT_GREEN_CYAN;
      end else if (hue_clamp >= 9'd60) begin
         st1_sector_in = SECT_YELLOW_GREEN;
      end else begin
         st1_sector_in = SECT_RED_YELLOW;
      end
      st1_mode_in      = color_mode;
      st1_raw_in.red   = req_chan.hue_or_red[BYTE_W-1:0];
      st1_raw_in.green = req_chan.sat_or_green;
      st1_raw_in.blue  = req_chan.val_or_blue;
   end

   // Stage 2 logic.
   always_comb begin
      sat_inv       = PCT_MAX - st1_sat_ff;
      st2_t_in      = T_W'(st1_sat_ff) * T_W'(6'd60 - st1_dist_ff)
                    + T_W'(sat_inv) * T_W'(60);
      st2_w_in      = W_W'(st1_val_ff) * W_W'(sat_inv);
      st2_x1_in     = X1_W'(st1_val_ff) * X1_W'(SCALE_CM);
      st2_mode_in   = st1_mode_ff;
      st2_raw_in    = st1_raw_ff;
      st2_sector_in = st1_sector_ff;
      st2_val_in    = st1_val_ff;
   end

   // Stage 3 logic.
   always_comb begin
      st3_n_in      = N_W'(st2_val_ff) * N_W'(st2_t_ff);
      st3_x2_in     = X2_W'(st2_w_ff) * X2_W'(SCALE_MM);
      st3_x1_in     = st2_x1_ff;
      st3_mode_in   = st2_mode_ff;
      st3_raw_in    = st2_raw_ff;
      st3_sector_in = st2_sector_ff;
   end

   // Stage 4 logic. Each estimate is the true quotient or one below it.
   always_comb begin
      prod_cm       = P1_W'(st3_x1_ff) * P1_W'(CM_RECIP);
      prod_mm       = P2_W'(st3_x2_ff) * P2_W'(MM_RECIP);
      st4_qcm_in    = prod_cm[CM_SHIFT +: BYTE_W];
      st4_qmm_in    = prod_mm[MM_SHIFT +: BYTE_W];
      st4_x3_in     = X3_W'(st3_n_ff) * X3_W'(SCALE_XM);
      st4_x1_in     = st3_x1_ff;
      st4_x2_in     = st3_x2_ff;
      st4_mode_in   = st3_mode_ff;
      st4_raw_in    = st3_raw_ff;
      st4_sector_in = st3_sector_ff;
   end

   // Stage 5 logic.
   always_comb begin
      rem_cm        = st4_x1_ff - X1_W'(st4_qcm_ff) * X1_W'(CM_DIV);
      rem_mm        = st4_x2_ff - X2_W'(st4_qmm_ff) * X2_W'(MM_DIV);
      st5_cm_in     = (rem_cm >= X1_W'(CM_DIV)) ? st4_qcm_ff + 8'd1 : st4_qcm_ff;
      st5_mm_in     = (rem_mm >= X2_W'(MM_DIV)) ? st4_qmm_ff + 8'd1 : st4_qmm_ff;
      prod_xm       = P3_W'(st4_x3_ff) * P3_W'(XM_RECIP);
      st5_qxm_in    = prod_xm[XM_SHIFT +: BYTE_W];
      st5_x3_in     = st4_x3_ff;
      st5_mode_in   = st4_mode_ff;
      st5_raw_in    = st4_raw_ff;
      st5_sector_in = st4_sector_ff;
   end

   // Stage 6 logic.
   always_comb begin
      rem_xm = st5_x3_ff - X3_W'(st5_qxm_ff) * X3_W'(XM_DIV);
      xm     = (rem_xm >= X3_W'(XM_DIV)) ? st5_qxm_ff + 8'd1 : st5_qxm_ff;
      unique case (st5_sector_ff)
         SECT_RED_YELLOW: begin
            hsv_color = '{red: st5_cm_ff, green: xm, blue: st5_mm_ff};
         end
         SECT_YELLOW_GREEN: begin
            hsv_color = '{red: xm, green: st5_cm_ff, blue: st5_mm_ff};
         end
         SECT_GREEN_CYAN: begin
            hsv_color = '{red: st5_mm_ff, green: st5_cm_ff, blue: xm};
         end
         SECT_CYAN_BLUE: begin
            hsv_color = '{red: st5_mm_ff, green: xm, blue: st5_cm_ff};
         end
         SECT_BLUE_MAGENTA: begin
            hsv_color = '{red: xm, green: st5_mm_ff, blue: st5_cm_ff};
         end
         default: begin
            hsv_color = '{red: st5_cm_ff, green: st5_mm_ff, blue: xm};
         end
      endcase
      st6_color_in = (st5_mode_ff == MODE_HSV) ? hsv_color : st5_raw_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st1_mode_ff   <= st1_mode_in;
         st1_raw_ff    <= st1_raw_in;
         st1_sector_ff <= st1_sector_in;
         st1_dist_ff   <= st1_dist_in;
         st1_sat_ff    <= st1_sat_in;
         st1_val_ff    <= st1_val_in;
      end
      if (adv[1]) begin
         st2_mode_ff   <= st2_mode_in;
         st2_raw_ff    <= st2_raw_in;
         st2_sector_ff <= st2_sector_in;
         st2_val_ff    <= st2_val_in;
         st2_t_ff      <= st2_t_in;
         st2_w_ff      <= st2_w_in;
         st2_x1_ff     <= st2_x1_in;
      end
      if (adv[2]) begin
         st3_mode_ff   <= st3_mode_in;
         st3_raw_ff    <= st3_raw_in;
         st3_sector_ff <= st3_sector_in;
         st3_n_ff      <= st3_n_in;
         st3_x2_ff     <= st3_x2_in;
         st3_x1_ff     <= st3_x1_in;
      end
      if (adv[3]) begin
         st4_mode_ff   <= st4_mode_in;
         st4_raw_ff    <= st4_raw_in;
         st4_sector_ff <= st4_sector_in;
         st4_x3_ff     <= st4_x3_in;
         st4_x1_ff     <= st4_x1_in;
         st4_x2_ff     <= st4_x2_in;
         st4_qcm_ff    <= st4_qcm_in;
         st4_qmm_ff    <= st4_qmm_in;
      end
      if (adv[4]) begin
         st5_mode_ff   <= st5_mode_in;
         st5_raw_ff    <= st5_raw_in;
         st5_sector_ff <= st5_sector_in;
         st5_x3_ff     <= st5_x3_in;
         st5_qxm_ff    <= st5_qxm_in;
         st5_cm_ff     <= st5_cm_in;
         st5_mm_ff     <= st5_mm_in;
      end
      if (adv[5]) begin
         st6_color_ff  <= st6_color_in;
      end
   end

`ifndef SYNTHESIS
   // The reciprocal estimate for c+m is never above the quotient nor two below it.
   a_cm_estimate: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (32'(st4_qcm_ff) * CM_DIV <= 32'(st4_x1_ff)) &&
                      (32'(st4_x1_ff) - 32'(st4_qcm_ff) * CM_DIV < 2 * CM_DIV))
      else $error("c+m reciprocal estimate out of bounds");

   // Same bound for the m estimate.
   a_mm_estimate: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (32'(st4_qmm_ff) * MM_DIV <= 32'(st4_x2_ff)) &&
                      (32'(st4_x2_ff) - 32'(st4_qmm_ff) * MM_DIV < 2 * MM_DIV))
      else $error("m reciprocal estimate out of bounds");

   // Same bound for the x+m estimate.
   a_xm_estimate: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (40'(st5_qxm_ff) * XM_DIV <= 40'(st5_x3_ff)) &&
                      (40'(st5_x3_ff) - 40'(st5_qxm_ff) * XM_DIV < 2 * XM_DIV))
      else $error("x+m reciprocal estimate out of bounds");
`endif

endmodule

@@ rtl/core/pclbc_serializer.sv @@
// -----------------------------------------------------------------------------
// Pixel color to LED bit codes: bit serializer
// Holds one RGB pixel and sends one code word per bit, red first, MSB first.
// -----------------------------------------------------------------------------
module pclbc_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pclbc_pkg::color_type     in_color,
   input  pclbc_pkg::code_cfg_type  codes,
   pclbc_rsp_if.source              rsp_chan
);
   import pclbc_pkg::*;

   localparam channel_type CHANNEL_BLUE = 2'd2;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BITS_PER_PIXEL - 1);

   logic                      busy_ff,  busy_in;
   logic [POS_W-1:0]          pos_ff,   pos_in;
   logic [BITS_PER_PIXEL-1:0] shift_ff, shift_in;
   logic                      rsp_fire;
   logic                      word_last;

   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign word_last = (pos_ff == POS_LAST);
   assign in_ready  = !busy_ff || (rsp_fire && word_last);

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      priority if (in_valid && in_ready) begin
         busy_in  = 1'b1;
         pos_in   = '0;
         shift_in = in_color;
      end else if (rsp_fire) begin
         if (word_last) begin
            busy_in = 1'b0;
         end else begin
            pos_in   = pos_ff + 5'd1;
            shift_in = {shift_ff[BITS_PER_PIXEL-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      shift_ff <= shift_in;
   end

   assign rsp_chan.valid     = busy_ff;
   assign rsp_chan.code_word = shift_ff[BITS_PER_PIXEL-1] ? codes.one_code
                                                          : codes.zero_code;
   assign rsp_chan.channel   = pos_ff[POS_W-1:BIT_INDEX_W];
   assign rsp_chan.bit_index = ~pos_ff[BIT_INDEX_W-1:0];
   assign rsp_chan.last      = word_last;

`ifndef SYNTHESIS
   // The final word of a pixel is always bit zero of blue.
   a_last_is_blue_lsb: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last |->
         (rsp_chan.channel == CHANNEL_BLUE) && (rsp_chan.bit_index == '0))
      else $error("last word is not blue bit zero");

   // A taken word that is not the last moves on to the next bit.
   a_bit_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !word_last |=> busy_ff && (pos_ff == $past(pos_ff) + 5'd1))
      else $error("bit position did not advance");

   // A pixel that starts from idle starts at its first bit.
   a_start_at_msb: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> (pos_ff == '0))
      else $error("pixel started mid-word");
`endif

endmodule

@@ rtl/core/pixel_color_to_led_bit_codes.sv @@
// -----------------------------------------------------------------------------
// Pixel color to LED bit codes
// Each request carries one pixel color, either RGB bytes or HSV (hue in
// degrees, saturation and value in percent) as selected by the color mode
// register. HSV input is clamped (hue to 360, saturation and value to 100) and
// converted to RGB with the six-sector formula, every channel truncated toward
// zero. Each pixel then leaves as 24 code words, red, green, blue, each most
// significant bit first, with one_code for a one bit and zero_code for a zero
// bit. The output sends one code word per cycle while the result side is
// ready, and the serializer takes the next pixel only once the last word of
// the current one is taken. The conversion is a six-stage pipeline ahead of
// the serializer: a pixel passes through the stage registers and then the
// serializer's shift register, and the pipeline takes up to six further
// requests while an earlier pixel is still being sent.
// Configuration should only be written while no request is in flight.
// -----------------------------------------------------------------------------
module pixel_color_to_led_bit_codes (
   input  logic                     clock,
   input  logic                     reset,
   pclbc_req_if.sink                req_chan,
   pclbc_rsp_if.source              rsp_chan,
   input  logic                     csr_write_enable,
   input  pclbc_pkg::csr_index_type csr_index,
   input  pclbc_pkg::csr_data_type  csr_write_data
);
   import pclbc_pkg::*;

   // Configuration registers. All three reset to zero, so both code words
   // read as zero until software writes them.
   logic     color_mode_ff, color_mode_in;
   code_type one_code_ff,   one_code_in;
   code_type zero_code_ff,  zero_code_in;

   // Link between the conversion pipeline and the serializer.
   logic         pipe_valid;
   logic         pipe_ready;
   color_type    pipe_color;
   code_cfg_type codes;

   // Register writes. A write to an index past the last register is dropped.
   always_comb begin
      color_mode_in = color_mode_ff;
      one_code_in   = one_code_ff;
      zero_code_in  = zero_code_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COLOR_MODE: begin
               color_mode_in = csr_write_data[0];
            end
            CSR_ONE_CODE: begin
               one_code_in = csr_write_data;
            end
            CSR_ZERO_CODE: begin
               zero_code_in = csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_RGB;
         one_code_ff   <= '0;
         zero_code_ff  <= '0;
      end else begin
         color_mode_ff <= color_mode_in;
         one_code_ff   <= one_code_in;
         zero_code_ff  <= zero_code_in;
      end
   end

   assign codes.one_code  = one_code_ff;
   assign codes.zero_code = zero_code_ff;

   // The mode is sampled when a request enters the pipeline and travels with
   // it; in RGB mode the raw bytes ride along and bypass the arithmetic.
   pclbc_color_pipe u_color_pipe (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .color_mode (color_mode_ff),
      .out_valid  (pipe_valid),
      .out_ready  (pipe_ready),
      .out_color  (pipe_color)
   );

   // The serializer takes the next pixel in the same cycle that the last word
   // of the current one is taken, so words of consecutive pixels leave back
   // to back without a gap.
   pclbc_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pipe_valid),
      .in_ready (pipe_ready),
      .in_color (pipe_color),
      .codes    (codes),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ dv/tb_pixel_color_to_led_bit_codes.sv @@
// -----------------------------------------------------------------------------
// Pixel color to LED bit codes: block testbench
// Sends pixel requests in RGB and HSV mode through the request channel. For
// each accepted request it predicts the 24 code words the block must send, and
// checks every result field against them in order. Directed requests cover the
// field extremes, every hue sector, clamping and the codes that are in use
// before any write. Random phases cover the rest, with random idling on both
// channels, a long result stall and sender pauses.
// -----------------------------------------------------------------------------
module tb_pixel_color_to_led_bit_codes;
   timeunit 1ns;
   timeprecision 1ps;

   import pclbc_pkg::*;

   // The index that decodes to no register. A write to it must change nothing.
   localparam csr_index_type CSR_UNUSED_INDEX = 2'd3;

   // Cycles the result side holds ready low during the backpressure test.
   // This is far longer than the pipeline needs to fill and stall its input.
   localparam int unsigned RESULT_HOLD_CYCLES = 200;

   // Fewest cycles to wait once every expected code word has arrived.
   localparam int unsigned SETTLE_CYCLES = 12;

   // One expected code word, with the same fields as the result channel.
   typedef struct packed {
      code_type      code_word;
      channel_type   channel;
      bit_index_type bit_index;
      logic          last;
   } led_code_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   pclbc_req_if req_bus ();
   pclbc_rsp_if rsp_bus ();

   pixel_color_to_led_bit_codes u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // The testbench's copy of the configuration registers. They are updated
   // when a write is issued, which is always while the block is idle.
   logic     cfg_color_mode;
   code_type cfg_one_code;
   code_type cfg_zero_code;

   // Code words predicted for accepted requests, oldest first.
   led_code_type pending_code_words[$];

   bit test_failed;

   // Random idling of each side, and a hand-off flag that asks the result
   // side to stall for a long stretch.
   bit sender_idle_enable;
   bit receiver_idle_enable;
   bit receiver_hold_request;

   // ------------------------------------------------------------------------
   // Clock and watchdog.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The timeout lies far beyond the slowest correct run, so reaching it can
   // only mean that the block has hung.
   initial begin
      #2_000_000;
      $display("[%0t] timeout: %0d code words still expected", $realtime,
               pending_code_words.size());
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction.
   // ------------------------------------------------------------------------

   // Converts one request to the RGB that the block sends, under the current
   // mode. HSV uses the six-sector formula in exact integer arithmetic with
   // every quotient truncated. The largest intermediate value is about 1.5e8,
   // so 32-bit unsigned arithmetic cannot overflow.
   function automatic color_type pixel_to_rgb(hue_type h, byte_type s, byte_type v);
      int unsigned hue, sat, val, hue_mod, hue_dist, peak, rising, floor_level;
      color_type rgb;
      if (cfg_color_mode == MODE_RGB) begin
         // Only the low byte of the hue field carries red.
         rgb.red   = h[BYTE_W-1:0];
         rgb.green = s;
         rgb.blue  = v;
         return rgb;
      end
      hue = (h > 360) ? 360 : h;
      sat = (s > 100) ? 100 : s;
      val = (v > 100) ? 100 : v;
      hue_mod = hue % 120;
      hue_dist = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
      peak = val * 255 / 100;
      rising = 255 * (val * sat * (60 - hue_dist) + 60 * val * (100 - sat)) / 600000;
      floor_level = 255 * val * (100 - sat) / 10000;
      // A hue of exactly 360 falls into sector six, which the block treats as
      // the last sector.
      case (hue / 60)
         0: rgb = {peak[7:0], rising[7:0], floor_level[7:0]};
         1: rgb = {rising[7:0], peak[7:0], floor_level[7:0]};
         2: rgb = {floor_level[7:0], peak[7:0], rising[7:0]};
         3: rgb = {floor_level[7:0], rising[7:0], peak[7:0]};
         4: rgb = {rising[7:0], floor_level[7:0], peak[7:0]};
         default: rgb = {peak[7:0], floor_level[7:0], rising[7:0]};
      endcase
      return rgb;
   endfunction

   // Appends the 24 code words of one accepted request: red, green, then
   // blue, each from its most significant bit down.
   task automatic queue_pixel_code_words(input hue_type h, input byte_type s,
                                         input byte_type v);
      color_type rgb;
      led_code_type word;
      rgb = pixel_to_rgb(h, s, v);
      for (int pos = 0; pos < BITS_PER_PIXEL; pos++) begin
         word.code_word = rgb[BITS_PER_PIXEL-1-pos] ? cfg_one_code : cfg_zero_code;
         word.channel   = channel_type'(pos / 8);
         word.bit_index = bit_index_type'(7 - pos % 8);
         word.last      = (pos == BITS_PER_PIXEL - 1);
         pending_code_words.push_back(word);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: ready with random stalls, and the result checker.
   // ------------------------------------------------------------------------

   // Ready changes only at the falling edge. A long hold-off is counted here,
   // in this process, once the stimulus asks for it.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold_request) begin
            receiver_hold_request = 1'b0;
            hold_left = RESULT_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (receiver_idle_enable) begin
            rsp_bus.ready <= ($urandom_range(99) >= 16);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         test_failed = 1'b1;
         $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, name,
                  want, got);
      end
   endfunction

   // Every accepted code word is compared, field by field, with the oldest
   // prediction.
   always @(posedge clock) begin
      led_code_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_code_words.size() == 0) begin
            test_failed = 1'b1;
            $display("[%0t] unexpected code word: expected none, got 0x%0h ch %0d bit %0d",
                     $realtime, rsp_bus.code_word, rsp_bus.channel, rsp_bus.bit_index);
         end else begin
            want = pending_code_words.pop_front();
            check_field("code_word", want.code_word, rsp_bus.code_word);
            check_field("channel", want.channel, rsp_bus.channel);
            check_field("bit_index", want.bit_index, rsp_bus.bit_index);
            check_field("last", want.last, rsp_bus.last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side and configuration writes.
   // ------------------------------------------------------------------------

   // Offers one pixel request and returns once it has been accepted. When
   // idling is on, valid may first drop for a few cycles. Valid is left high
   // afterwards, so back-to-back requests keep it high without a glitch.
   task automatic send_pixel(input hue_type h, input byte_type s, input byte_type v);
      int unsigned gap;
      if (sender_idle_enable && $urandom_range(99) < 16) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.hue_or_red   <= h;
      req_bus.sat_or_green <= s;
      req_bus.val_or_blue  <= v;
      do @(posedge clock); while (!req_bus.ready);
      queue_pixel_code_words(h, s, v);
   endtask

   // Drops valid and waits until every predicted code word has come back,
   // then lets the pipeline settle. The block is idle afterwards.
   task automatic wait_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_code_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input csr_data_type data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_COLOR_MODE: cfg_color_mode = data[0];
         CSR_ONE_CODE:   cfg_one_code   = data;
         CSR_ZERO_CODE:  cfg_zero_code  = data;
         default: ;
      endcase
   endtask

   // Writes all three registers. The upper bits of the mode write are random,
   // because only bit 0 may count.
   task automatic configure(input logic mode, input code_type one, input code_type zero);
      csr_data_type mode_data;
      mode_data = csr_data_type'($urandom);
      mode_data[0] = mode;
      write_csr(CSR_COLOR_MODE, mode_data);
      write_csr(CSR_ONE_CODE, one);
      write_csr(CSR_ZERO_CODE, zero);
   endtask

   // Picks a random request suited to the current mode. In HSV mode most
   // requests lie inside the valid ranges, with a few clamped ones mixed in.
   task automatic pick_random_pixel(output hue_type h, output byte_type s,
                                    output byte_type v);
      if (cfg_color_mode == MODE_HSV && $urandom_range(99) < 80) begin
         h = hue_type'($urandom_range(360));
         s = byte_type'($urandom_range(100));
         v = byte_type'($urandom_range(100));
      end else begin
         h = hue_type'($urandom);
         s = byte_type'($urandom);
         v = byte_type'($urandom);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Right after reset the block is in RGB mode and both codes are zero, so
   // every code word must be zero whatever the color.
   task automatic test_codes_after_reset();
      send_pixel(9'h1FF, 8'hFF, 8'hFF);
      send_pixel(9'h0A5, 8'h5A, 8'hC3);
      wait_until_drained();
   endtask

   // A write to the index that has no register must leave the mode and both
   // codes as they are. All ones would switch the mode to HSV if it were taken.
   task automatic test_unused_csr_index();
      configure(MODE_RGB, 16'hA5A5, 16'h5A5A);
      write_csr(CSR_UNUSED_INDEX, 16'hFFFF);
      send_pixel(9'h0F0, 8'h0F, 8'h3C);
      wait_until_drained();
   endtask

   // RGB extremes. The ninth hue bit must be ignored.
   task automatic test_rgb_extremes();
      configure(MODE_RGB, 16'hFFFF, 16'h0000);
      send_pixel(9'h000, 8'h00, 8'h00);
      send_pixel(9'h1FF, 8'hFF, 8'hFF);
      send_pixel(9'h100, 8'h55, 8'hAA);
      wait_until_drained();
      configure(MODE_RGB, 16'h0000, 16'hFFFF);
      send_pixel(9'h0AA, 8'h80, 8'h01);
      send_pixel(9'h17F, 8'hFE, 8'h7F);
      wait_until_drained();
   endtask

   // Each sector's first hue, the last hue of sectors 0, 1 and 5, hue 360,
   // clamping of hue, saturation and value, and the gray and black corners.
   task automatic test_hsv_sectors_and_clamping();
      hue_type  hues[15] = '{0, 59, 60, 119, 120, 180, 240, 300, 359, 360, 361, 511,
                             200, 90, 45};
      byte_type sats[15] = '{100, 100, 100, 100, 100, 50, 100, 37, 100, 100, 100, 255,
                             0, 100, 101};
      byte_type vals[15] = '{100, 100, 100, 50, 100, 100, 100, 73, 100, 100, 100, 255,
                             100, 0, 200};
      configure(MODE_HSV, 16'h1234, 16'hFEDC);
      for (int i = 0; i < 15; i++) send_pixel(hues[i], sats[i], vals[i]);
      wait_until_drained();
   endtask

   // A phase of random requests under one configuration.
   task automatic test_random_pixels(input logic mode, input code_type one,
                                     input code_type zero, input int unsigned count);
      hue_type  h;
      byte_type s, v;
      configure(mode, one, zero);
      repeat (count) begin
         pick_random_pixel(h, s, v);
         send_pixel(h, s, v);
      end
      wait_until_drained();
   endtask

   // The result side stalls for a long stretch while requests keep coming,
   // so the pipeline fills and must hold off its input without losing data.
   task automatic test_result_backpressure();
      hue_type  h;
      byte_type s, v;
      configure(MODE_HSV, code_type'($urandom), code_type'($urandom));
      @(posedge clock);
      receiver_hold_request = 1'b1;
      repeat (16) begin
         pick_random_pixel(h, s, v);
         send_pixel(h, s, v);
      end
      wait_until_drained();
   endtask

   // The sender pauses until every result is out, and then starts again with
   // the block fully empty, a few times in a row.
   task automatic test_sender_pause();
      hue_type  h;
      byte_type s, v;
      configure(MODE_RGB, code_type'($urandom), code_type'($urandom));
      repeat (4) begin
         repeat ($urandom_range(3, 8)) begin
            pick_random_pixel(h, s, v);
            send_pixel(h, s, v);
         end
         wait_until_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_COLOR_MODE;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.hue_or_red    = '0;
      req_bus.sat_or_green  = '0;
      req_bus.val_or_blue   = '0;
      cfg_color_mode        = MODE_RGB;
      cfg_one_code          = '0;
      cfg_zero_code         = '0;
      test_failed           = 1'b0;
      sender_idle_enable    = 1'b0;
      receiver_idle_enable  = 1'b1;
      receiver_hold_request = 1'b0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      sender_idle_enable = 1'b1;
      test_codes_after_reset();
      test_unused_csr_index();
      test_rgb_extremes();
      test_hsv_sectors_and_clamping();

      test_random_pixels(MODE_RGB, code_type'($urandom), code_type'($urandom), 30);
      test_random_pixels(MODE_HSV, 16'hFFFF, 16'h0000, 30);

      // A long stretch where neither side ever idles.
      sender_idle_enable   = 1'b0;
      receiver_idle_enable = 1'b0;
      test_random_pixels(MODE_HSV, code_type'($urandom), code_type'($urandom), 30);
      sender_idle_enable   = 1'b1;
      receiver_idle_enable = 1'b1;

      test_random_pixels(MODE_RGB, 16'h0000, 16'hFFFF, 30);
      // Equal codes: every code word must be the same regardless of the bit.
      test_random_pixels(MODE_HSV, 16'h7E81, 16'h7E81, 30);

      test_result_backpressure();
      test_sender_pause();

      wait_until_drained();
      if (!test_failed)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
